// ===== hdl/u8dec_pkg.sv =====
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

   localparam int COUNT_WIDTH    = 16;
   localparam int LIMIT_WIDTH    = 16;
   localparam int TOTAL_WIDTH    = 16;
   localparam int CMP_WIDTH      = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
   localparam int POINT_WIDTH    = 21;
   localparam int SEQ_WIDTH      = 3;
   localparam int PEND_WIDTH     = 2;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 48;
   localparam int RSP_USER_WIDTH = 2;

   localparam logic [0:0] REG_COUNT_LIMIT = 1'b0;

   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] PAYLOAD_MASK = 8'h3F;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

   typedef enum logic [1:0] {
      KIND_CHAR    = 2'd0,
      KIND_END     = 2'd1,
      KIND_INVALID = 2'd2
   } u8dec_kind_type;

   typedef struct packed {
      u8dec_kind_type           kind;
      logic [POINT_WIDTH-1:0]   code_point;
      logic [SEQ_WIDTH-1:0]     seq_bytes;
      logic [TOTAL_WIDTH-1:0]   char_total;
      logic                     all_ascii;
   } u8dec_result_type;

   typedef struct packed {
      logic             has_result;
      u8dec_result_type result;
   } u8dec_step_type;

endpackage

// ===== hdl/u8dec_csr.sv =====
// ----------------------------------------------------------------------------
// u8dec_csr
// APB register file holding the per-string character limit.
// ----------------------------------------------------------------------------
module u8dec_csr
   import u8dec_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output logic [LIMIT_WIDTH-1:0]    count_limit
);

   logic [LIMIT_WIDTH-1:0] limit_ff;
   logic [LIMIT_WIDTH-1:0] limit_in;
   logic                   hit_limit;

   assign hit_limit  = (csr_paddr[CSR_ADDR_WIDTH-1:2] == REG_COUNT_LIMIT);
   assign csr_pready = 1'b1;

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit_limit) begin
         limit_in = csr_pwdata[LIMIT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign csr_prdata  = hit_limit ? CSR_DATA_WIDTH'(limit_ff) : '0;
   assign count_limit = limit_ff;

endmodule

// ===== hdl/u8dec_core.sv =====
// ----------------------------------------------------------------------------
// u8dec_core
// Per-string decode state and the combinational byte step.
// ----------------------------------------------------------------------------
module u8dec_core
   import u8dec_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             data_byte,
   input  logic [LIMIT_WIDTH-1:0] count_limit,
   output u8dec_step_type         step
);

   logic [PEND_WIDTH-1:0]  pending_ff, pending_in;
   logic [POINT_WIDTH-1:0] accum_ff, accum_in;
   logic [SEQ_WIDTH-1:0]   seq_ff, seq_in;
   logic [COUNT_WIDTH-1:0] counter_ff, counter_in;
   logic                   ascii_ff, ascii_in;
   logic                   discard_ff, discard_in;

   logic [COUNT_WIDTH-1:0] counter_inc;
   logic [POINT_WIDTH-1:0] accum_shift;
   logic                   limit_hit;

   function automatic logic [TOTAL_WIDTH-1:0] total_of(input logic [COUNT_WIDTH-1:0] c);
      logic [CMP_WIDTH-1:0] ext;
      ext = CMP_WIDTH'(c);
      if (ext > CMP_WIDTH'(TOTAL_MAX)) begin
         return TOTAL_MAX;
      end
      return ext[TOTAL_WIDTH-1:0];
   endfunction

   assign counter_inc = (counter_ff != COUNT_MAX) ? counter_ff + 1'b1 : counter_ff;
   assign accum_shift = {accum_ff[POINT_WIDTH-7:0], data_byte[5:0] & PAYLOAD_MASK[5:0]};
   assign limit_hit   = (count_limit != '0) &&
                        (CMP_WIDTH'(counter_ff) >= CMP_WIDTH'(count_limit));

   always_comb begin
      pending_in = pending_ff;
      accum_in   = accum_ff;
      seq_in     = seq_ff;
      counter_in = counter_ff;
      ascii_in   = ascii_ff & ~data_byte[7];
      discard_in = discard_ff;

      step.has_result        = 1'b0;
      step.result.kind       = KIND_CHAR;
      step.result.code_point = '0;
      step.result.seq_bytes  = '0;
      step.result.char_total = total_of(counter_ff);
      step.result.all_ascii  = ascii_ff & ~data_byte[7];

      if (data_byte == 8'h00) begin
         // terminator: report unless discarding, and start a new string
         step.has_result  = ~discard_ff;
         step.result.kind = (pending_ff != '0) ? KIND_INVALID : KIND_END;
         pending_in = '0;
         accum_in   = '0;
         seq_in     = '0;
         counter_in = '0;
         ascii_in   = 1'b1;
         discard_in = 1'b0;
      end else if (discard_ff) begin
         step.has_result = 1'b0;
      end else if (pending_ff != '0) begin
         if ((data_byte & CONT_MASK) != CONT_CODE) begin
            step.has_result  = 1'b1;
            step.result.kind = KIND_INVALID;
            pending_in = '0;
            accum_in   = '0;
            seq_in     = '0;
            discard_in = 1'b1;
         end else if (pending_ff == PEND_WIDTH'(1)) begin
            step.has_result        = 1'b1;
            step.result.kind       = KIND_CHAR;
            step.result.code_point = accum_shift;
            step.result.seq_bytes  = seq_ff;
            step.result.char_total = total_of(counter_inc);
            pending_in = '0;
            accum_in   = '0;
            seq_in     = '0;
            counter_in = counter_inc;
         end else begin
            pending_in = pending_ff - 1'b1;
            accum_in   = accum_shift;
         end
      end else if (limit_hit) begin
         step.has_result = 1'b0;
      end else if (data_byte[7] == 1'b0) begin
         step.has_result        = 1'b1;
         step.result.kind       = KIND_CHAR;
         step.result.code_point = POINT_WIDTH'(data_byte);
         step.result.seq_bytes  = SEQ_WIDTH'(1);
         step.result.char_total = total_of(counter_inc);
         counter_in = counter_inc;
      end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
         pending_in = PEND_WIDTH'(1);
         accum_in   = POINT_WIDTH'(data_byte[4:0]);
         seq_in     = SEQ_WIDTH'(2);
      end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
         pending_in = PEND_WIDTH'(2);
         accum_in   = POINT_WIDTH'(data_byte[3:0]);
         seq_in     = SEQ_WIDTH'(3);
      end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
         pending_in = PEND_WIDTH'(3);
         accum_in   = POINT_WIDTH'(data_byte[2:0]);
         seq_in     = SEQ_WIDTH'(4);
      end else begin
         step.has_result  = 1'b1;
         step.result.kind = KIND_INVALID;
         discard_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         accum_ff   <= '0;
         seq_ff     <= '0;
         counter_ff <= '0;
         ascii_ff   <= 1'b1;
         discard_ff <= 1'b0;
      end else if (step_en) begin
         pending_ff <= pending_in;
         accum_ff   <= accum_in;
         seq_ff     <= seq_in;
         counter_ff <= counter_in;
         ascii_ff   <= ascii_in;
         discard_ff <= discard_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_idle_seq_clear : assert property (@(posedge clock) disable iff (reset)
      (pending_ff == '0) |-> (seq_ff == '0))
      else $error("sequence length left over with nothing pending");

   a_discard_no_pending : assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (pending_ff == '0))
      else $error("continuation bytes pending while discarding");

   a_char_counts : assert property (@(posedge clock) disable iff (reset)
      (step_en && step.has_result && step.result.kind == KIND_CHAR) |=> (counter_ff != '0))
      else $error("decoded character left counter at zero");
`endif

endmodule

// ===== hdl/utf8_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Lax UTF-8 decoder for zero-terminated byte strings, one byte per clock
// unless a stalled result holds the byte back.
//   channel  dir  fields
//   req_     in   tdata[7:0] data_byte
//   rsp_     out  tuser[1:0] result_kind, tdata code_point..all_ascii
//   csr_     in   APB, count_limit at 0x0
//
// one byte accepted per clock unless stalled, result registered after its byte
// the byte-to-byte decode state closes through a combinational step in the core
// synchronous reset clears all control and string state, limit reads zero
// a stalled result blocks only bytes that would give another result
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top
   import u8dec_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // data_byte[7:0]
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // code_point[20:0], seq_bytes[23:21], char_total[39:24], all_ascii[40]
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // result_kind[1:0]
   output logic [RSP_USER_WIDTH-1:0] rsp_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   out_valid_ff, out_valid_in;
   u8dec_result_type       out_ff;
   logic [LIMIT_WIDTH-1:0] count_limit;
   u8dec_step_type         step;
   logic                   advance;
   logic                   out_load;

   u8dec_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .count_limit (count_limit)
   );

   u8dec_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .data_byte   (in_byte_ff),
      .count_limit (count_limit),
      .step        (step)
   );

   assign advance    = in_valid_ff && (!step.has_result || !out_valid_ff || rsp_tready);
   assign out_load   = advance && step.has_result;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[7:0];
      end
      if (out_load) begin
         out_ff <= step.result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = RSP_DATA_WIDTH'({out_ff.all_ascii, out_ff.char_total,
                                        out_ff.seq_bytes, out_ff.code_point});

endmodule
